FILE: sv/stl_pkg.sv
// shared types and constants of the s-expression token lexer
// token kinds, character codes and the token and queue entry records
// no dependencies
package stl_pkg;

  // token kinds as seen on the result port
  typedef enum logic [3:0] {
    K_LPAREN  = 4'd0,
    K_VECOPEN = 4'd1,
    K_RPAREN  = 4'd2,
    K_QUOTE   = 4'd3,
    K_QUASI   = 4'd4,
    K_UNQUOTE = 4'd5,
    K_SPLICE  = 4'd6,
    K_TRUE    = 4'd7,
    K_FALSE   = 4'd8,
    K_NUMBER  = 4'd9,
    K_SYMCHAR = 4'd10,
    K_SYMEND  = 4'd11,
    K_STRCHAR = 4'd12,
    K_STREND  = 4'd13,
    K_EOF     = 4'd14,
    K_ERROR   = 4'd15
  } kind_e;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // largest number magnitude
  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  // default depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // one token
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] num;
    logic [7:0]         txt;
    logic               ovf;
  } tok_t;

  // tokens caused by one input transaction: one or two
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } pair_t;

  // queue write from the front
  typedef struct packed {
    logic  valid;
    pair_t data;
  } wr_t;

  // oldest queue entry towards the back
  typedef struct packed {
    logic  valid;
    pair_t data;
  } head_t;

  // token with no payload
  function automatic tok_t mk_tok(kind_e kind, logic [7:0] txt);
    tok_t t;
    t.kind = kind;
    t.num  = '0;
    t.txt  = txt;
    t.ovf  = 1'b0;
    return t;
  endfunction

endpackage

FILE: sv/stl_front.sv
// lexer front end: mode state, number accumulation and token classification
// emits one queue entry per accepted transaction that causes tokens
// depends on stl_pkg
module stl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    ch_i,
  input  logic          end_of_input_i,
  output stl_pkg::wr_t  wr_o
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_COMMA, M_HASH, M_STRING, M_ESCAPE, M_SYMBOL, M_NUMBER
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic        tok_v;
    tok_t        tok;
    logic        num_start;
    logic [30:0] mag;
    logic        neg;
  } idle_t;

  mode_e       mode_q, mode_d;
  logic [30:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic        sat_q, sat_d;

  logic        pre_v, post_v, run_idle;
  tok_t        pre, post, num_tok;
  idle_t       id;
  logic [31:0] mag_ext;
  logic [34:0] acc;
  logic [7:0]  esc_ch;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI) ||
           (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
           (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_COMMA);
  endfunction

  // classification of a character seen from idle
  function automatic idle_t lex_idle(logic [7:0] c);
    idle_t r;
    r.mode      = M_IDLE;
    r.tok_v     = 1'b0;
    r.tok       = mk_tok(K_EOF, 8'd0);
    r.num_start = 1'b0;
    r.mag       = '0;
    r.neg       = 1'b0;
    if (is_space(c)) begin
      r.mode = M_IDLE;
    end else begin
      case (c)
        CH_SEMI:   r.mode = M_COMMENT;
        CH_SQUOTE: begin r.tok_v = 1'b1; r.tok = mk_tok(K_QUOTE, 8'd0); end
        CH_BTICK:  begin r.tok_v = 1'b1; r.tok = mk_tok(K_QUASI, 8'd0); end
        CH_DQUOTE: r.mode = M_STRING;
        CH_LPAREN: begin r.tok_v = 1'b1; r.tok = mk_tok(K_LPAREN, 8'd0); end
        CH_RPAREN: begin r.tok_v = 1'b1; r.tok = mk_tok(K_RPAREN, 8'd0); end
        CH_COMMA:  r.mode = M_COMMA;
        CH_HASH:   r.mode = M_HASH;
        default: begin
          if (is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS)) begin
            r.mode      = M_NUMBER;
            r.num_start = 1'b1;
            r.mag       = is_digit(c) ? {27'd0, c[3:0]} : '0;
            r.neg       = (c == CH_MINUS);
          end else begin
            r.mode  = M_SYMBOL;
            r.tok_v = 1'b1;
            r.tok   = mk_tok(K_SYMCHAR, c);
          end
        end
      endcase
    end
    return r;
  endfunction

  // number token from the accumulated magnitude and sign
  always_comb begin
    mag_ext      = {1'b0, mag_q};
    num_tok      = mk_tok(K_NUMBER, 8'd0);
    num_tok.num  = neg_q ? $signed(32'd0 - mag_ext) : $signed(mag_ext);
    num_tok.ovf  = sat_q;
    acc          = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {31'd0, ch_i[3:0]};
    id           = lex_idle(ch_i);
    case (ch_i)
      CH_N:    esc_ch = CH_LF;
      CH_T:    esc_ch = CH_TAB;
      default: esc_ch = ch_i;
    endcase
  end

  // mode update and token selection
  always_comb begin
    mode_d   = mode_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    sat_d    = sat_q;
    pre_v    = 1'b0;
    pre      = mk_tok(K_EOF, 8'd0);
    post_v   = 1'b0;
    post     = mk_tok(K_EOF, 8'd0);
    run_idle = 1'b0;
    if (end_of_input_i) begin
      unique case (mode_q)
        M_COMMA: begin pre_v = 1'b1; pre = mk_tok(K_UNQUOTE, 8'd0); end
        M_HASH:  begin pre_v = 1'b1; pre = mk_tok(K_ERROR, 8'd0); end
        M_STRING, M_ESCAPE: begin pre_v = 1'b1; pre = mk_tok(K_STREND, 8'd0); end
        M_SYMBOL: begin pre_v = 1'b1; pre = mk_tok(K_SYMEND, 8'd0); end
        M_NUMBER: begin
          pre_v = 1'b1;
          pre   = num_tok;
          mag_d = '0;
          neg_d = 1'b0;
          sat_d = 1'b0;
        end
        M_IDLE, M_COMMENT: pre_v = 1'b0;
        default: pre_v = 1'b0;
      endcase
      mode_d = M_IDLE;
      post_v = 1'b1;
      post   = mk_tok(K_EOF, 8'd0);
    end else begin
      unique case (mode_q)
        M_COMMENT: begin
          if (ch_i == CH_LF) mode_d = M_IDLE;
        end
        M_COMMA: begin
          mode_d = M_IDLE;
          pre_v  = 1'b1;
          if (ch_i == CH_AT) begin
            pre = mk_tok(K_SPLICE, 8'd0);
          end else begin
            pre      = mk_tok(K_UNQUOTE, 8'd0);
            run_idle = 1'b1;
          end
        end
        M_HASH: begin
          mode_d = M_IDLE;
          pre_v  = 1'b1;
          case (ch_i)
            CH_LPAREN: pre = mk_tok(K_VECOPEN, 8'd0);
            CH_T:      pre = mk_tok(K_TRUE, 8'd0);
            CH_F:      pre = mk_tok(K_FALSE, 8'd0);
            default:   pre = mk_tok(K_ERROR, 8'd0);
          endcase
        end
        M_STRING: begin
          if (ch_i == CH_DQUOTE) begin
            mode_d = M_IDLE;
            pre_v  = 1'b1;
            pre    = mk_tok(K_STREND, 8'd0);
          end else if (ch_i == CH_BSLASH) begin
            mode_d = M_ESCAPE;
          end else begin
            pre_v = 1'b1;
            pre   = mk_tok(K_STRCHAR, ch_i);
          end
        end
        M_ESCAPE: begin
          mode_d = M_STRING;
          pre_v  = 1'b1;
          pre    = mk_tok(K_STRCHAR, esc_ch);
        end
        M_SYMBOL: begin
          pre_v = 1'b1;
          if (is_delim(ch_i)) begin
            pre      = mk_tok(K_SYMEND, 8'd0);
            run_idle = 1'b1;
          end else begin
            pre = mk_tok(K_SYMCHAR, ch_i);
          end
        end
        M_NUMBER: begin
          if (is_digit(ch_i)) begin
            if (acc > {4'd0, MAG_MAX}) begin
              mag_d = MAG_MAX;
              sat_d = 1'b1;
            end else begin
              mag_d = acc[30:0];
            end
          end else begin
            pre_v    = 1'b1;
            pre      = num_tok;
            mag_d    = '0;
            neg_d    = 1'b0;
            sat_d    = 1'b0;
            run_idle = 1'b1;
          end
        end
        M_IDLE:  run_idle = 1'b1;
        default: run_idle = 1'b1;
      endcase
      // delimiter or fresh character lexed from idle
      if (run_idle) begin
        mode_d = id.mode;
        post_v = id.tok_v;
        post   = id.tok;
        if (id.num_start) begin
          mag_d = id.mag;
          neg_d = id.neg;
          sat_d = 1'b0;
        end
      end
    end
  end

  // queue entry: first token in slot 0, second in slot 1
  always_comb begin
    wr_o.valid     = step_i && (pre_v || post_v);
    wr_o.data.two  = pre_v && post_v;
    wr_o.data.tok0 = pre_v ? pre : post;
    wr_o.data.tok1 = post;
  end

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      mag_q  <= '0;
      neg_q  <= 1'b0;
      sat_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      sat_q  <= sat_d;
    end
  end

endmodule

FILE: sv/stl_queue.sv
// token queue between lexer front end and result back end
// holds token pairs in registers, one write and one head read per cycle
// depends on stl_pkg
module stl_queue #(
  parameter int Depth = stl_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stl_pkg::wr_t   wr_i,
  input  logic           release_i,
  output stl_pkg::head_t head_o,
  output logic           full_o
);
  import stl_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pair_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign do_wr  = wr_i.valid;
  assign do_rd  = release_i && (cnt_q != '0);
  assign full_o = (cnt_q == CntW'(Depth));

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

endmodule

FILE: sv/stl_back.sv
// result back end: walks the tokens of the oldest queue entry
// presents one token per result transaction and marks the last of each pair
// depends on stl_pkg
module stl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stl_pkg::head_t            head_i,
  output logic                      release_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output stl_pkg::kind_e            kind_o,
  output logic signed [31:0]        number_value_o,
  output logic [7:0]                text_char_o,
  output logic                      overflow_o,
  output logic                      last_o
);
  import stl_pkg::*;

  logic sel_q, sel_d;
  logic take;
  tok_t cur;

  assign empty_o = !head_i.valid;
  assign take    = pop_i && head_i.valid;
  assign cur     = sel_q ? head_i.data.tok1 : head_i.data.tok0;

  assign kind_o         = cur.kind;
  assign number_value_o = cur.num;
  assign text_char_o    = cur.txt;
  assign overflow_o     = cur.ovf;
  assign last_o         = sel_q || !head_i.data.two;

  // entry is done once its last token is taken
  assign release_o = take && last_o;

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

FILE: sv/sexpr_token_lexer_top.sv
// top level of the s-expression token lexer
// front end, token queue and result back end; depends on stl_pkg
//
//   channel   direction  handshake             transaction on
//   input     in         push / full           push && !full
//   result    out        empty / pop           pop && !empty
//
// an input is lexed in the cycle it is accepted, one character per cycle while not full
// each transaction causes zero, one or two results; its entry enters the queue at once
// one result per cycle while popped and not empty; two-result characters take two pops
// full rises when all QueueDepth entries of the token queue are occupied
// reset returns the lexer to idle and empties the queue, with no clearing pass
module sexpr_token_lexer_top #(
  parameter int QueueDepth = stl_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         ch_i,
  input  logic               end_of_input_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         kind_o,
  output logic signed [31:0] number_value_o,
  output logic [7:0]         text_char_o,
  output logic               overflow_o,
  output logic               last_o
);
  import stl_pkg::*;

  wr_t   wr;
  head_t head;
  logic  step;
  logic  rel;
  kind_e kind;

  assign step   = push && !full;
  assign kind_o = kind;

  stl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .wr_o           (wr)
  );

  stl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .release_i (rel),
    .head_o    (head),
    .full_o    (full)
  );

  stl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .release_o      (rel),
    .empty_o        (empty),
    .pop_i          (pop),
    .kind_o         (kind),
    .number_value_o (number_value_o),
    .text_char_o    (text_char_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o)
  );

  // an end mark always leaves at least an eof token waiting
  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && end_of_input_i |=> !empty)
    else $error("end of input accepted but no result queued");

  // eof is always the final token of its transaction
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind == K_EOF) |-> last_o)
    else $error("eof token not marked last");

  // only number tokens carry a value or an overflow flag
  a_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind != K_NUMBER) |-> (number_value_o == 32'sd0) && !overflow_o)
    else $error("non-number token carries number payload");

endmodule

FILE: test/sexpr_token_lexer_top_tb.sv
// self-checking testbench of the s-expression token lexer top level
// directed table, then tokenized random character streams under four idle and stall settings
// depends on stl_pkg and sexpr_token_lexer_top
module sexpr_token_lexer_top_tb;
  import stl_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int PhaseItems  = 500;
  localparam int DrainCycles = 20;

  // lexer modes of the predictor
  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_COMMA, M_HASH, M_STRING, M_ESCAPE, M_SYMBOL, M_NUMBER
  } scan_mode_e;

  // one expected result transaction
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] num;
    logic [7:0]         txt;
    logic               ovf;
    logic               last;
  } lexeme_t;

  // one input transaction, with optional typed expectation (n results)
  typedef struct packed {
    logic [7:0]  c;
    logic        e;
    logic [1:0]  n;
    kind_e       k0;
    logic [31:0] v0;
    logic        o0;
    kind_e       k1;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         ch_i = 8'h00;
  logic               end_of_input_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [3:0]         kind_o;
  logic signed [31:0] number_value_o;
  logic [7:0]         text_char_o;
  logic               overflow_o;
  logic               last_o;

  row_t cur_row = '0;

  // predictor state
  scan_mode_e  scan_mode = M_IDLE;
  logic [30:0] num_mag = '0;
  logic        num_neg = 1'b0;
  logic        num_sat = 1'b0;

  lexeme_t step_out[$];
  lexeme_t pending_tokens[$];
  row_t    dir_tab[$];
  row_t    stim_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  sexpr_token_lexer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .number_value_o (number_value_o),
    .text_char_o    (text_char_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // character classes
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI || c == CH_SPACE ||
           c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SQUOTE ||
           c == CH_DQUOTE || c == CH_COMMA;
  endfunction

  function automatic void emit(kind_e k, logic [31:0] n, logic [7:0] t, logic o);
    lexeme_t x;
    x.kind = k;
    x.num  = n;
    x.txt  = t;
    x.ovf  = o;
    x.last = 1'b0;
    step_out.push_back(x);
  endfunction

  // close the open number and clear its accumulator
  function automatic void flush_number();
    logic [31:0] v;
    v = num_neg ? -{1'b0, num_mag} : {1'b0, num_mag};
    emit(K_NUMBER, v, 8'h00, num_sat);
    num_mag  = '0;
    num_neg  = 1'b0;
    num_sat  = 1'b0;
  endfunction

  // character seen with no token open
  function automatic void lex_fresh(logic [7:0] c);
    scan_mode = M_IDLE;
    if (is_space(c)) return;
    case (c)
      CH_SEMI:   scan_mode = M_COMMENT;
      CH_SQUOTE: emit(K_QUOTE, '0, 8'h00, 1'b0);
      CH_BTICK:  emit(K_QUASI, '0, 8'h00, 1'b0);
      CH_DQUOTE: scan_mode = M_STRING;
      CH_LPAREN: emit(K_LPAREN, '0, 8'h00, 1'b0);
      CH_RPAREN: emit(K_RPAREN, '0, 8'h00, 1'b0);
      CH_COMMA:  scan_mode = M_COMMA;
      CH_HASH:   scan_mode = M_HASH;
      default: begin
        if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
          scan_mode = M_NUMBER;
          num_mag   = is_digit(c) ? 31'(c - CH_ZERO) : '0;
          num_neg   = (c == CH_MINUS);
          num_sat   = 1'b0;
        end else begin
          scan_mode = M_SYMBOL;
          emit(K_SYMCHAR, '0, c, 1'b0);
        end
      end
    endcase
  endfunction

  // end-of-input mark: close what is open, then eof
  function automatic void lex_eoi();
    case (scan_mode)
      M_COMMA:            emit(K_UNQUOTE, '0, 8'h00, 1'b0);
      M_HASH:             emit(K_ERROR, '0, 8'h00, 1'b0);
      M_STRING, M_ESCAPE: emit(K_STREND, '0, 8'h00, 1'b0);
      M_SYMBOL:           emit(K_SYMEND, '0, 8'h00, 1'b0);
      M_NUMBER:           flush_number();
      default: ;
    endcase
    scan_mode = M_IDLE;
    emit(K_EOF, '0, 8'h00, 1'b0);
  endfunction

  // one character in the current mode
  function automatic void lex_char(logic [7:0] c);
    logic [35:0] prod;
    case (scan_mode)
      M_COMMENT: begin
        if (c == CH_LF) scan_mode = M_IDLE;
      end
      M_COMMA: begin
        scan_mode = M_IDLE;
        if (c == CH_AT) begin
          emit(K_SPLICE, '0, 8'h00, 1'b0);
        end else begin
          emit(K_UNQUOTE, '0, 8'h00, 1'b0);
          lex_fresh(c);
        end
      end
      M_HASH: begin
        scan_mode = M_IDLE;
        if (c == CH_LPAREN) emit(K_VECOPEN, '0, 8'h00, 1'b0);
        else if (c == CH_T) emit(K_TRUE, '0, 8'h00, 1'b0);
        else if (c == CH_F) emit(K_FALSE, '0, 8'h00, 1'b0);
        else emit(K_ERROR, '0, 8'h00, 1'b0);
      end
      M_STRING: begin
        if (c == CH_DQUOTE) begin
          scan_mode = M_IDLE;
          emit(K_STREND, '0, 8'h00, 1'b0);
        end else if (c == CH_BSLASH) begin
          scan_mode = M_ESCAPE;
        end else begin
          emit(K_STRCHAR, '0, c, 1'b0);
        end
      end
      M_ESCAPE: begin
        scan_mode = M_STRING;
        if (c == CH_N) emit(K_STRCHAR, '0, CH_LF, 1'b0);
        else if (c == CH_T) emit(K_STRCHAR, '0, CH_TAB, 1'b0);
        else emit(K_STRCHAR, '0, c, 1'b0);
      end
      M_SYMBOL: begin
        if (is_delim(c)) begin
          emit(K_SYMEND, '0, 8'h00, 1'b0);
          lex_fresh(c);
        end else begin
          emit(K_SYMCHAR, '0, c, 1'b0);
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          prod = {5'd0, num_mag} * 36'd10 + {28'd0, c - CH_ZERO};
          if (prod > {5'd0, MAG_MAX}) begin
            num_mag = MAG_MAX;
            num_sat = 1'b1;
          end else begin
            num_mag = prod[30:0];
          end
        end else begin
          flush_number();
          lex_fresh(c);
        end
      end
      default: lex_fresh(c);
    endcase
  endfunction

  function automatic row_t mk_row(logic [7:0] c, logic e, logic [1:0] n, kind_e k0,
                                  logic [31:0] v0, logic o0, kind_e k1);
    row_t r;
    r.c  = c;
    r.e  = e;
    r.n  = n;
    r.k0 = k0;
    r.v0 = v0;
    r.o0 = o0;
    r.k1 = k1;
    return r;
  endfunction

  function automatic void add_ch(logic [7:0] c, logic e);
    stim_q.push_back(mk_row(c, e, 2'd0, K_EOF, '0, 1'b0, K_EOF));
  endfunction

  // random byte that does not end a symbol
  function automatic logic [7:0] sym_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_delim(b));
    return b;
  endfunction

  // one random lexeme, mostly well formed, appended to the stimulus
  function automatic void gen_lexeme();
    int pick;
    int len;
    int sel;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 15) begin
      sel = $urandom_range(5);
      case (sel)
        0: add_ch(CH_SPACE, 1'b0);
        1: add_ch(CH_TAB, 1'b0);
        2: add_ch(CH_LF, 1'b0);
        3: add_ch(CH_CR, 1'b0);
        4: add_ch(8'h0B, 1'b0);
        default: add_ch(8'h0C, 1'b0);
      endcase
    end else if (pick < 25) begin
      sel = $urandom_range(3);
      case (sel)
        0: add_ch(CH_LPAREN, 1'b0);
        1: add_ch(CH_RPAREN, 1'b0);
        2: add_ch(CH_SQUOTE, 1'b0);
        default: add_ch(CH_BTICK, 1'b0);
      endcase
    end else if (pick < 32) begin
      add_ch(CH_COMMA, 1'b0);
      if ($urandom_range(1)) add_ch(CH_AT, 1'b0);
    end else if (pick < 38) begin
      add_ch(CH_HASH, 1'b0);
      sel = $urandom_range(3);
      case (sel)
        0: add_ch(CH_LPAREN, 1'b0);
        1: add_ch(CH_T, 1'b0);
        2: add_ch(CH_F, 1'b0);
        default: add_ch(8'($urandom_range(255)), 1'b0);
      endcase
    end else if (pick < 55) begin
      // number: optional sign, short or long digit run, optional terminator
      sel = $urandom_range(2);
      if (sel == 1) add_ch(CH_PLUS, 1'b0);
      if (sel == 2) add_ch(CH_MINUS, 1'b0);
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(4);
      if (sel == 0 && len == 0) len = 1;
      repeat (len) add_ch(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      sel = $urandom_range(3);
      case (sel)
        0: add_ch(CH_SPACE, 1'b0);
        1: add_ch(CH_RPAREN, 1'b0);
        2: add_ch(8'($urandom_range(255)), 1'b0);
        default: ;
      endcase
    end else if (pick < 70) begin
      // symbol: a start byte that opens a symbol, then body bytes
      do b = 8'($urandom_range(255));
      while (is_space(b) || is_delim(b) || is_digit(b) || b == CH_BTICK ||
             b == CH_HASH || b == CH_PLUS || b == CH_MINUS);
      add_ch(b, 1'b0);
      repeat ($urandom_range(5)) add_ch(sym_byte(), 1'b0);
      if ($urandom_range(1)) add_ch(CH_SPACE, 1'b0);
    end else if (pick < 82) begin
      // string with escapes, sometimes left open
      add_ch(CH_DQUOTE, 1'b0);
      repeat ($urandom_range(6)) begin
        if ($urandom_range(4) == 0) begin
          add_ch(CH_BSLASH, 1'b0);
          sel = $urandom_range(2);
          case (sel)
            0: add_ch(CH_N, 1'b0);
            1: add_ch(CH_T, 1'b0);
            default: add_ch(8'($urandom_range(255)), 1'b0);
          endcase
        end else begin
          do b = 8'($urandom_range(255)); while (b == CH_DQUOTE || b == CH_BSLASH);
          add_ch(b, 1'b0);
        end
      end
      if ($urandom_range(9) != 0) add_ch(CH_DQUOTE, 1'b0);
    end else if (pick < 88) begin
      // comment to end of line
      add_ch(CH_SEMI, 1'b0);
      repeat ($urandom_range(5)) begin
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        add_ch(b, 1'b0);
      end
      add_ch(CH_LF, 1'b0);
    end else if (pick < 93) begin
      add_ch(8'($urandom_range(255)), 1'b1);
    end else begin
      add_ch(8'($urandom_range(255)), 1'b0);
    end
  endfunction

  // present one input transaction and wait until it is taken
  task automatic drive_item(input row_t rw);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    ch_i           <= rw.c;
    end_of_input_i <= rw.e;
    cur_row        <= rw;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // result side stalls
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // prediction on input transactions, checking on result transactions, watchdog
  always @(posedge clk_i) begin
    lexeme_t w;
    if (rst_ni && push && !full) begin
      step_out.delete();
      if (end_of_input_i) lex_eoi();
      else lex_char(ch_i);
      // typed rows replace the predicted tokens
      if (cur_row.n != 2'd0) begin
        step_out.delete();
        emit(cur_row.k0, cur_row.v0, 8'h00, cur_row.o0);
        if (cur_row.n == 2'd2) emit(cur_row.k1, '0, 8'h00, 1'b0);
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
    end
    if (rst_ni && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d num %0d txt %02h ovf %0b last %0b",
                   $time, kind_o, number_value_o, text_char_o, overflow_o, last_o);
      end else begin
        w = pending_tokens.pop_front();
        if (kind_o !== w.kind || number_value_o !== w.num || text_char_o !== w.txt ||
            overflow_o !== w.ovf || last_o !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t exp/got k %0d/%0d n %0d/%0d t %02h/%02h o %0b/%0b l %0b/%0b",
                     $time, w.kind, kind_o, w.num, number_value_o, w.txt, text_char_o,
                     w.ovf, overflow_o, w.last, last_o);
        end
      end
    end
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    // directed table: c, eoi, typed count, kind0, value0, ovf0, kind1
    dir_tab.push_back(mk_row(8'h00, 1'b1, 2'd1, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_LPAREN, 1'b0, 2'd1, K_LPAREN, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_RPAREN, 1'b0, 2'd1, K_RPAREN, '0, 1'b0, K_EOF));
    // bad hash consumes the byte
    dir_tab.push_back(mk_row(CH_HASH, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(8'h78, 1'b0, 2'd1, K_ERROR, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_HASH, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_T, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_COMMA, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_AT, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_BTICK, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    // sign alone gives zero
    dir_tab.push_back(mk_row(CH_MINUS, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_SPACE, 1'b0, 2'd1, K_NUMBER, '0, 1'b0, K_EOF));
    // string with a newline escape
    dir_tab.push_back(mk_row(CH_DQUOTE, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_BSLASH, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_N, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_DQUOTE, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    // symbol of extreme bytes closed by end of input
    dir_tab.push_back(mk_row(8'hFF, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(8'h00, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(8'hFF, 1'b1, 2'd2, K_SYMEND, '0, 1'b0, K_EOF));
    // saturating number ended by a comment, then end of input in the comment
    repeat (10) dir_tab.push_back(mk_row(CH_NINE, 1'b0, 2'd0, K_EOF, '0, 1'b0, K_EOF));
    dir_tab.push_back(mk_row(CH_SEMI, 1'b0, 2'd1, K_NUMBER, {1'b0, MAG_MAX}, 1'b1, K_EOF));
    dir_tab.push_back(mk_row(8'h00, 1'b1, 2'd1, K_EOF, '0, 1'b0, K_EOF));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (ph == 0) begin
        foreach (dir_tab[i]) drive_item(dir_tab[i]);
      end
      stim_q.delete();
      while (stim_q.size() < PhaseItems) gen_lexeme();
      while (stim_q.size() > 0) drive_item(stim_q.pop_front());
      // hold off until every token has drained
      push <= 1'b0;
      @(posedge clk_i);
      while (pending_tokens.size() != 0) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
